/* rtl/core/nbkr_pkg.sv */
// Shared types and codes for the null-bind key resolver.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package nbkr_pkg;

    // Event kinds. Any other code is handled like KIND_OTHER.
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_OTHER   = 2'd2;

    // Conflict modes
    localparam logic [2:0] MODE_LAST      = 3'd0;
    localparam logic [2:0] MODE_PRIMARY   = 3'd1;
    localparam logic [2:0] MODE_SECONDARY = 3'd2;
    localparam logic [2:0] MODE_NEUTRAL   = 3'd3;
    localparam logic [2:0] MODE_DISTANCE  = 3'd4;

    // Output actions
    localparam logic ACT_REGISTER   = 1'b0;
    localparam logic ACT_UNREGISTER = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BEHAVIOR_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_OUT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_POS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY_POS   = 2'd3;

    localparam logic [7:0] SECONDARY_POS_RESET = 8'd1;

    typedef struct packed {
        logic [2:0] behavior_mode;
        logic [7:0] bottom_level;
        logic [7:0] primary_key_position;
        logic [7:0] secondary_key_position;
    } cfg_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       is_secondary;
        logic [7:0] keycode_in;
        logic [7:0] primary_distance;
        logic [7:0] secondary_distance;
    } event_t;

    typedef struct packed {
        logic       action;
        logic [7:0] key_position;
        logic [7:0] keycode_out;
        logic       last;
    } result_t;

    // Results of one event: up to two, first in r0.
    typedef struct packed {
        result_t    r0;
        result_t    r1;
        logic [1:0] count;
    } batch_t;

endpackage

`default_nettype wire

/* rtl/core/nbkr_in_stage.sv */
// Input register for key events with its stream handshake.
// Depends on nbkr_pkg for the event type.
`default_nettype none

module nbkr_in_stage (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire nbkr_pkg::event_t in_event,
    input  wire logic            take,
    output logic                 ev_valid,
    output nbkr_pkg::event_t     ev
);
    import nbkr_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    event_t ev_reg;

    // The register frees up in the same cycle its event is consumed.
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            ev_reg <= in_event;
        end
    end

    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

endmodule

`default_nettype wire

/* rtl/core/nbkr_resolve.sv */
// Per-key state and the conflict resolution for one key pair.
// Depends on nbkr_pkg for types, modes and action codes.
`default_nettype none

module nbkr_resolve (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire nbkr_pkg::cfg_t   cfg,
    input  wire nbkr_pkg::event_t ev,
    input  wire logic             commit,
    output nbkr_pkg::batch_t      batch
);
    import nbkr_pkg::*;

    logic [1:0][7:0] held_keycode_reg;
    logic [1:0][7:0] held_keycode_next;
    logic [1:0]      reported_reg;
    logic [1:0]      reported_next;

    logic            idx;
    logic            oth;
    logic [1:0][7:0] hk1;
    logic [1:0]      rp1;
    logic            rel_emit;
    logic [1:0]      want;
    logic [1:0]      chg;
    logic [1:0][7:0] travel;
    logic [1:0][7:0] pos;
    logic            bottomed;
    result_t         rel_res;
    result_t         c0;
    result_t         c1;

    assign idx  = ev.is_secondary;
    assign oth  = ~ev.is_secondary;
    assign travel = {ev.secondary_distance, ev.primary_distance};
    assign pos  = {cfg.secondary_key_position, cfg.primary_key_position};
    assign bottomed = (cfg.bottom_level != 8'd0)
                   && (ev.primary_distance >= cfg.bottom_level)
                   && (ev.secondary_distance >= cfg.bottom_level);

    // Apply the event to the stored keycode; a release of a reported key
    // unregisters it first.
    always_comb
    begin
        hk1      = held_keycode_reg;
        rp1      = reported_reg;
        rel_emit = 1'b0;
        if (ev.kind == KIND_PRESS)
        begin
            hk1[idx] = ev.keycode_in;
        end
        else if (ev.kind == KIND_RELEASE)
        begin
            rel_emit = reported_reg[idx];
            rp1[idx] = 1'b0;
            hk1[idx] = 8'd0;
        end
    end

    // Decide which keys should be reported.
    always_comb
    begin
        want[0] = (hk1[0] != 8'd0);
        want[1] = (hk1[1] != 8'd0);
        if (want[0] && want[1])
        begin
            if (bottomed)
            begin
                want = 2'b11;
            end
            else if (cfg.behavior_mode == MODE_DISTANCE)
            begin
                want[idx] = (travel[idx] >= travel[oth]);
                want[oth] = (travel[idx] < travel[oth]);
            end
            else if (ev.kind == KIND_PRESS)
            begin
                // Unknown modes fall through to reporting the other key.
                want[idx] = (cfg.behavior_mode == MODE_LAST)
                         || ((cfg.behavior_mode == MODE_PRIMARY) && !idx)
                         || ((cfg.behavior_mode == MODE_SECONDARY) && idx);
                want[oth] = (cfg.behavior_mode != MODE_NEUTRAL) && !want[idx];
            end
            else
            begin
                want = rp1;
            end
        end
    end

    assign chg = want ^ rp1;

    always_comb
    begin
        rel_res.action       = ACT_UNREGISTER;
        rel_res.key_position = pos[idx];
        rel_res.keycode_out  = held_keycode_reg[idx];
        rel_res.last         = 1'b0;

        c0.action       = rp1[0] ? ACT_UNREGISTER : ACT_REGISTER;
        c0.key_position = pos[0];
        c0.keycode_out  = hk1[0];
        c0.last         = 1'b0;

        c1.action       = rp1[1] ? ACT_UNREGISTER : ACT_REGISTER;
        c1.key_position = pos[1];
        c1.keycode_out  = hk1[1];
        c1.last         = 1'b0;
    end

    // Take the first two of: release, key 0 change, key 1 change.
    always_comb
    begin
        if (rel_emit)
        begin
            batch.r0    = rel_res;
            batch.r1    = chg[0] ? c0 : c1;
            batch.count = (chg[0] || chg[1]) ? 2'd2 : 2'd1;
        end
        else if (chg[0])
        begin
            batch.r0    = c0;
            batch.r1    = c1;
            batch.count = chg[1] ? 2'd2 : 2'd1;
        end
        else
        begin
            batch.r0    = c1;
            batch.r1    = c1;
            batch.count = chg[1] ? 2'd1 : 2'd0;
        end
        batch.r0.last = (batch.count == 2'd1);
        batch.r1.last = 1'b1;
    end

    assign held_keycode_next = commit ? hk1 : held_keycode_reg;
    assign reported_next     = commit ? want : reported_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_keycode_reg <= '0;
            reported_reg     <= '0;
        end
        else
        begin
            held_keycode_reg <= held_keycode_next;
            reported_reg     <= reported_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/nbkr_out_buf.sv */
// Two-slot result register that plays out the actions of one event.
// Depends on nbkr_pkg for the result and batch types.
`default_nettype none

module nbkr_out_buf (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire nbkr_pkg::batch_t batch,
    output logic                  load_ok,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output nbkr_pkg::result_t     out_res
);
    import nbkr_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    result_t    head_reg;
    result_t    tail_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // A new batch fits once the slots are empty after this cycle's transfer.
    assign load_ok   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    always_comb
    begin
        if (load)
        begin
            cnt_next = batch.count;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            head_reg <= batch.r0;
            tail_reg <= batch.r1;
        end
        else if (pop)
        begin
            head_reg <= tail_reg;
        end
    end

    assign out_res = head_reg;

endmodule

`default_nettype wire

/* rtl/core/null_bind_key_resolver.sv */
// Top level of the null-bind (SOCD) resolver for one key pair.
// Depends on nbkr_pkg, nbkr_in_stage, nbkr_resolve and nbkr_out_buf.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------
//  s_axis   | in        | key event: kind, key select, keycode, distances
//  m_axis   | out       | action: register/unregister, position, keycode
//  cfg      | in        | write-only: mode, bottom-out, key positions
//
// An event is registered on transfer and resolved once the output slots
// can take it, which loads its zero to two actions into the output slots;
// the first action is offered from the slot register. The output slots
// send one action per cycle while m_axis_tready is high, and load the next
// event's actions as the last action of the current one transfers.
// Reset clears the held keycodes and the reported flags and returns the
// configuration to its defaults.
// A stall on m_axis holds the current action and backs up into s_axis.
`default_nettype none

module null_bind_key_resolver (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] keycode_in, [15:8] primary_distance, [23:16] secondary_distance
    input  wire logic [23:0]                   s_axis_tdata,
    // [1:0] kind, [2] is_secondary
    input  wire logic [2:0]                    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [7:0] key_position, [15:8] keycode_out
    output logic [15:0]                        m_axis_tdata,
    // [0] action
    output logic [0:0]                         m_axis_tuser,
    output logic                               m_axis_tlast,
    input  wire logic                          cfg_wr_en,
    input  wire logic [nbkr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_wdata
);
    import nbkr_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    event_t  in_event;
    event_t  ev;
    logic    ev_valid;
    logic    load_ok;
    logic    proc;
    batch_t  batch;
    result_t out_res;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BEHAVIOR_MODE: cfg_next.behavior_mode          = cfg_wdata[2:0];
                CFG_BOTTOM_OUT:    cfg_next.bottom_level           = cfg_wdata;
                CFG_PRIMARY_POS:   cfg_next.primary_key_position   = cfg_wdata;
                CFG_SECONDARY_POS: cfg_next.secondary_key_position = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.behavior_mode          <= MODE_LAST;
            cfg_reg.bottom_level           <= 8'd0;
            cfg_reg.primary_key_position   <= 8'd0;
            cfg_reg.secondary_key_position <= SECONDARY_POS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign in_event.kind               = s_axis_tuser[1:0];
    assign in_event.is_secondary       = s_axis_tuser[2];
    assign in_event.keycode_in         = s_axis_tdata[7:0];
    assign in_event.primary_distance   = s_axis_tdata[15:8];
    assign in_event.secondary_distance = s_axis_tdata[23:16];

    assign proc = ev_valid && load_ok;

    nbkr_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_event (in_event),
        .take     (proc),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    nbkr_resolve u_resolve (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .ev     (ev),
        .commit (proc),
        .batch  (batch)
    );

    nbkr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (proc),
        .batch     (batch),
        .load_ok   (load_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {out_res.keycode_out, out_res.key_position};
    assign m_axis_tuser = out_res.action;
    assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire
